/* hw/rtl/strip_fan_triangle_assembly_defines.svh */
// Assertion macros for the checker file of the triangle assembly block.
`ifndef STRIP_FAN_TRIANGLE_ASSEMBLY_DEFINES_SVH
`define STRIP_FAN_TRIANGLE_ASSEMBLY_DEFINES_SVH

// Property checked at every rising clock edge outside of reset.
`define SFTA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Property checked at every rising clock edge, reset cycles included.
`define SFTA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/sfta_pkg.sv */
package sfta_pkg;

    // Primitive kind, latched from the first vertex of each primitive.
    typedef enum logic {
        MODE_STRIP = 1'b0,
        MODE_FAN   = 1'b1
    } t_mode;

    // Corners per triangle word, corner a in the lowest bits.
    localparam int TRI_CORNERS = 3;

    // Depth of the triangle queue between the assembly stage and the output stage.
    localparam int FIFO_DEPTH = 4;

endpackage

/* hw/rtl/strip_fan_triangle_assembly.sv */
// A finished triangle passes the assembly register, the queue and the output register in turn.
// One vertex per cycle unless stalled; a four-triangle queue decouples assembly from output.
// Back-pressure on the master side stalls the slave side only once that queue is full.
// Reset is synchronous and active low; it empties the queue and output and starts a new
// primitive with the next vertex.
module strip_fan_triangle_assembly
    import sfta_pkg::*;
#(
    parameter int INDEX_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: vertex_index
    input  logic [((INDEX_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // tuser: fan_mode in bit 0, first_vertex in bit 1
    input  logic [1:0]            s_axis_tuser,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: corner_a, corner_b, corner_c from the lowest bits up, zero filled to whole bytes
    output logic [((TRI_CORNERS*INDEX_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

    localparam int TRI_W      = TRI_CORNERS * INDEX_WIDTH;
    localparam int OUT_DATA_W = ((TRI_W + 7) / 8) * 8;

    logic             push_valid;
    logic             push_ready;
    logic [TRI_W-1:0] push_tri;
    logic             pop_valid;
    logic             pop;
    logic [TRI_W-1:0] pop_tri;
    logic [TRI_W-1:0] out_tri;

    // The assembly stage holds the primitive's vertex history and classifies each word:
    // the first vertex latches the strip or fan kind, the third and later form a triangle that
    // is kept only if its corners differ (a three-vertex primitive is always kept).
    sfta_front #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_vertex     (s_axis_tdata[INDEX_WIDTH-1:0]),
        .i_fan        (s_axis_tuser[0]),
        .i_first      (s_axis_tuser[1]),
        .i_last       (s_axis_tlast),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_tri   (push_tri)
    );

    // Short queue of finished triangles so either side may stall on its own.
    sfta_fifo #(
        .WIDTH (TRI_W)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_tri),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_data   (pop_tri)
    );

    // Output register that drives the master side.
    sfta_back #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (pop_valid),
        .o_pop   (pop),
        .i_tri   (pop_tri),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tri   (out_tri)
    );

    assign m_axis_tdata = OUT_DATA_W'(out_tri);

endmodule

/* hw/rtl/sfta_front.sv */
module sfta_front
    import sfta_pkg::*;
#(
    parameter int INDEX_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [INDEX_WIDTH-1:0]             i_vertex,
    input  logic                               i_fan,
    input  logic                               i_first,
    input  logic                               i_last,
    output logic                               o_push_valid,
    input  logic                               i_push_ready,
    output logic [TRI_CORNERS*INDEX_WIDTH-1:0] o_push_tri
);

    logic                               r_vld;
    logic [TRI_CORNERS*INDEX_WIDTH-1:0] r_tri;
    logic [INDEX_WIDTH-1:0]             r_anchor;
    logic [INDEX_WIDTH-1:0]             r_older;
    logic [INDEX_WIDTH-1:0]             r_newer;
    logic [1:0]                         r_seen;
    logic                               r_parity;
    t_mode                              r_mode;

    logic                               fire;
    logic                               start;
    logic                               emit;
    logic                               distinct;
    logic [INDEX_WIDTH-1:0]             ca;
    logic [INDEX_WIDTH-1:0]             cb;
    logic [INDEX_WIDTH-1:0]             cc;

    assign o_ready      = !r_vld || i_push_ready;
    assign fire         = i_valid && o_ready;
    assign o_push_valid = r_vld;
    assign o_push_tri   = r_tri;

    // Pick the corners for the current vertex and decide whether a triangle comes out.
    always_comb begin
        start = i_first || (r_seen == 2'd0);
        if (r_seen == 2'd2 && i_last) begin
            // Exactly three vertices: plain triangle, no repeat check.
            ca = r_older;
            cb = r_newer;
            cc = i_vertex;
        end else if (r_mode == MODE_FAN) begin
            ca = r_newer;
            cb = i_vertex;
            cc = r_anchor;
        end else if (!r_parity) begin
            ca = r_older;
            cb = i_vertex;
            cc = r_newer;
        end else begin
            ca = r_older;
            cb = r_newer;
            cc = i_vertex;
        end
        distinct = (ca != cb) && (cb != cc) && (cc != ca);
        emit = !start && ((r_seen == 2'd2 && i_last) || (r_seen >= 2'd2 && distinct));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_seen   <= 2'd0;
            r_parity <= 1'b0;
        end else begin
            if (fire) begin
                r_vld <= emit;
                if (i_last) begin
                    // The primitive ends here; the next vertex opens a new one.
                    r_seen   <= 2'd0;
                    r_parity <= 1'b0;
                end else if (start) begin
                    r_seen   <= 2'd1;
                    r_parity <= 1'b1;
                end else begin
                    if (r_seen != 2'd3) begin
                        r_seen <= r_seen + 2'd1;
                    end
                    r_parity <= !r_parity;
                end
            end else if (i_push_ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_tri <= {cc, cb, ca};
            if (start) begin
                r_mode   <= t_mode'(i_fan);
                r_anchor <= i_vertex;
                r_older  <= '0;
                r_newer  <= i_vertex;
            end else begin
                r_older <= r_newer;
                r_newer <= i_vertex;
            end
        end
    end

endmodule

/* hw/rtl/sfta_fifo.sv */
module sfta_fifo
    import sfta_pkg::*;
#(
    parameter int WIDTH = 48
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [FIFO_DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CW'(FIFO_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_data   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == AW'(FIFO_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == AW'(FIFO_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

/* hw/rtl/sfta_back.sv */
module sfta_back
    import sfta_pkg::*;
#(
    parameter int INDEX_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_avail,
    output logic                               o_pop,
    input  logic [TRI_CORNERS*INDEX_WIDTH-1:0] i_tri,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [TRI_CORNERS*INDEX_WIDTH-1:0] o_tri
);

    logic                               r_vld;
    logic [TRI_CORNERS*INDEX_WIDTH-1:0] r_tri;

    // Refill the output register whenever it is empty or being taken.
    assign o_pop   = i_avail && (!r_vld || i_ready);
    assign o_valid = r_vld;
    assign o_tri   = r_tri;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_pop) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tri <= i_tri;
        end
    end

endmodule

/* hw/rtl/sfta_checker.sv */
`include "strip_fan_triangle_assembly_defines.svh"

module sfta_checker
    import sfta_pkg::*;
#(
    parameter int INDEX_WIDTH = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [((INDEX_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input logic [1:0]            s_axis_tuser,
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [((TRI_CORNERS*INDEX_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

    // A stalled output word stays put until it is taken.
    `SFTA_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")

    // Reset leaves no triangle on the output.
    `SFTA_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid right after reset")

    // With the output register empty the queue cannot be full, so input is taken.
    `SFTA_ASSERT(a_idle_ready, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready, "input stalled while output is idle")

endmodule

bind strip_fan_triangle_assembly sfta_checker #(.INDEX_WIDTH(INDEX_WIDTH)) u_sfta_checker (.*);

/* bench/triangle_stream_check.sv */
`timescale 1ns / 1ps

module triangle_stream_check
    import sfta_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vtx_valid,
    input  logic        i_vtx_ready,
    input  logic [15:0] i_vtx_data,   // vertex_index
    input  logic [1:0]  i_vtx_user,   // fan_mode, first_vertex
    input  logic        i_vtx_last,   // last_vertex
    input  logic        i_tri_valid,
    input  logic        i_tri_ready,
    input  logic [47:0] i_tri_data,   // corner_a, corner_b, corner_c
    output int          o_mismatches,
    output int          o_pending,
    output int          o_triangles
);

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
    } t_triangle;

    // Own copy of the assembly state.
    logic [15:0] anchor_idx;
    logic [15:0] older_idx;
    logic [15:0] newer_idx;
    logic [1:0]  seen_count;
    logic        odd_position;
    t_mode       prim_mode;

    t_triangle   triangles_due[$];
    int          mismatch_count = 0;
    int          triangle_count = 0;

    // Advances the state by one vertex and queues the triangle it completes, if any.
    task automatic assemble_vertex(input logic [15:0] idx, input t_mode mode_in,
                                   input logic first, input logic last);
        t_triangle shape;
        logic      emit;
        emit  = 1'b0;
        shape = '0;
        if (first || seen_count == 2'd0) begin
            prim_mode    = mode_in;
            anchor_idx   = idx;
            older_idx    = '0;
            newer_idx    = idx;
            seen_count   = 2'd1;
            odd_position = 1'b1;
        end else begin
            if (seen_count == 2'd2 && last) begin
                // Three-vertex primitive: sent as is, repeats included.
                shape = '{older_idx, newer_idx, idx};
                emit  = 1'b1;
            end else if (seen_count >= 2'd2) begin
                if (prim_mode == MODE_FAN)
                    shape = '{newer_idx, idx, anchor_idx};
                else if (!odd_position)
                    shape = '{older_idx, idx, newer_idx};
                else
                    shape = '{older_idx, newer_idx, idx};
                emit = (shape.a != shape.b) && (shape.b != shape.c) && (shape.c != shape.a);
            end
            older_idx = newer_idx;
            newer_idx = idx;
            if (seen_count < 2'd3)
                seen_count = seen_count + 2'd1;
            odd_position = ~odd_position;
        end
        if (last) begin
            seen_count   = 2'd0;
            odd_position = 1'b0;
        end
        if (emit)
            triangles_due = {triangles_due, shape};
    endtask

    task automatic check_triangle(input logic [47:0] word);
        t_triangle want;
        t_triangle got;
        got = '{word[15:0], word[31:16], word[47:32]};
        triangle_count++;
        if (triangles_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("[%0t] unexpected triangle a=%h b=%h c=%h",
                         $realtime, got.a, got.b, got.c);
        end else begin
            want = triangles_due.pop_front();
            if (got.a != want.a || got.b != want.b || got.c != want.c) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] mismatch: expected a=%h b=%h c=%h, got a=%h b=%h c=%h",
                             $realtime, want.a, want.b, want.c, got.a, got.b, got.c);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            anchor_idx   = '0;
            older_idx    = '0;
            newer_idx    = '0;
            seen_count   = 2'd0;
            odd_position = 1'b0;
            prim_mode    = MODE_STRIP;
            triangles_due.delete();
        end else begin
            if (i_vtx_valid && i_vtx_ready)
                assemble_vertex(i_vtx_data, t_mode'(i_vtx_user[0]), i_vtx_user[1], i_vtx_last);
            if (i_tri_valid && i_tri_ready)
                check_triangle(i_tri_data);
        end
        o_mismatches <= mismatch_count;
        o_pending    <= triangles_due.size();
        o_triangles  <= triangle_count;
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import sfta_pkg::*;

    localparam int IDX_W          = 16;
    localparam int RANDOM_VERTICES = 1800;
    localparam int PAUSE_EVERY    = 400;
    localparam int DRAIN_CYCLES   = 16;
    localparam int CYCLE_LIMIT    = 500000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    // Vertex side of the block.
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata: vertex_index in bits 15:0
    logic [15:0] s_axis_tdata = '0;
    // tuser: fan_mode in bit 0, first_vertex in bit 1
    logic [1:0]  s_axis_tuser = '0;
    // tlast: last_vertex
    logic        s_axis_tlast = 1'b0;

    // Triangle side of the block.
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata: corner_a in bits 15:0, corner_b in bits 31:16, corner_c in bits 47:32
    logic [47:0] m_axis_tdata;

    int          mismatches;
    int          triangles_pending;
    int          triangles_checked;

    // When a side is calm it stops idling, so bursts at full rate are mixed with sparse traffic.
    bit          sender_calm = 1'b0;
    bit          receiver_calm = 1'b0;
    int          vertices_sent = 0;
    int          cycle_count = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    strip_fan_triangle_assembly #(
        .INDEX_WIDTH(IDX_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // The checker watches both channels, predicts every triangle and compares.
    triangle_stream_check u_triangle_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vtx_valid  (s_axis_tvalid),
        .i_vtx_ready  (s_axis_tready),
        .i_vtx_data   (s_axis_tdata),
        .i_vtx_user   (s_axis_tuser),
        .i_vtx_last   (s_axis_tlast),
        .i_tri_valid  (m_axis_tvalid),
        .i_tri_ready  (m_axis_tready),
        .i_tri_data   (m_axis_tdata),
        .o_mismatches (mismatches),
        .o_pending    (triangles_pending),
        .o_triangles  (triangles_checked)
    );

    // Idle cycles before the next word on either side.
    function automatic int pick_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    // Presents one vertex word and returns at the edge where it is taken. With no gap,
    // tvalid stays high and only the payload changes, so it is never dropped and raised
    // within one time step.
    task automatic send_vertex(input logic [15:0] idx, input t_mode mode_in,
                               input logic first, input logic last);
        int gap;
        gap = pick_gap(sender_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= idx;
        s_axis_tuser  <= {first, logic'(mode_in)};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        vertices_sent++;
    endtask

    // Holds the vertex side idle until every predicted triangle has been taken. The first
    // edge lets the checker's count catch up with the word accepted just before.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (triangles_pending != 0) @(posedge i_clk);
    endtask

    // Receiver: after each triangle word it draws a stall, then waits with tready high.
    initial begin : triangle_sink
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = pick_gap(receiver_calm);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // Watchdog: a hung handshake or a lost triangle ends the run here.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d triangles outstanding",
                 cycle_count, triangles_pending);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : vertex_source
        int    len;
        int    flaw;
        int    next_pause;
        int    directed_count;
        int    failures;
        bit    narrow;
        t_mode prim_mode;
        t_mode mode_bit;
        logic  first_mark;
        logic  last_mark;
        logic [15:0] idx;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Right after reset a vertex without a first mark still opens a
        // primitive; here it is a three-vertex one at the index extremes.
        send_vertex(16'hFFFF, MODE_STRIP, 1'b0, 1'b0);
        send_vertex(16'h0000, MODE_STRIP, 1'b0, 1'b0);
        send_vertex(16'h1234, MODE_STRIP, 1'b0, 1'b1);
        // First and last mark on the same vertex: nothing comes out.
        send_vertex(16'h0005, MODE_FAN, 1'b1, 1'b1);
        // Three vertices all alike still give one triangle.
        send_vertex(16'h0009, MODE_STRIP, 1'b1, 1'b0);
        send_vertex(16'h0009, MODE_STRIP, 1'b0, 1'b0);
        send_vertex(16'h0009, MODE_STRIP, 1'b0, 1'b1);
        // A two-vertex primitive is too short.
        send_vertex(16'h0030, MODE_STRIP, 1'b1, 1'b0);
        send_vertex(16'h0031, MODE_STRIP, 1'b0, 1'b1);
        // Strip with both winding orders and repeated corners that are dropped.
        send_vertex(16'h0001, MODE_STRIP, 1'b1, 1'b0);
        send_vertex(16'h0002, MODE_STRIP, 1'b0, 1'b0);
        send_vertex(16'h0003, MODE_STRIP, 1'b0, 1'b0);
        send_vertex(16'h0004, MODE_STRIP, 1'b0, 1'b0);
        send_vertex(16'h0004, MODE_STRIP, 1'b0, 1'b0);
        send_vertex(16'h0005, MODE_STRIP, 1'b0, 1'b1);
        // Fan whose mode bit flips later on (ignored) and that returns to its hub vertex.
        send_vertex(16'h000A, MODE_FAN, 1'b1, 1'b0);
        send_vertex(16'h000B, MODE_STRIP, 1'b0, 1'b0);
        send_vertex(16'h000C, MODE_STRIP, 1'b0, 1'b0);
        send_vertex(16'h000A, MODE_FAN, 1'b0, 1'b0);
        send_vertex(16'h8000, MODE_STRIP, 1'b0, 1'b1);
        // A first mark in mid-primitive abandons the open one and restarts.
        send_vertex(16'h0020, MODE_STRIP, 1'b1, 1'b0);
        send_vertex(16'h0021, MODE_STRIP, 1'b0, 1'b0);
        send_vertex(16'h0022, MODE_STRIP, 1'b1, 1'b0);
        send_vertex(16'h0023, MODE_STRIP, 1'b0, 1'b0);
        send_vertex(16'h0024, MODE_STRIP, 1'b0, 1'b1);
        directed_count = vertices_sent;

        // The sender holds off until the block has delivered everything.
        wait_drained();

        // Random part: mostly well-framed primitives of random length and content. Some use
        // a tiny index pool so that repeated corners are common; a few lose a mark or carry
        // stray marks in the middle.
        next_pause = directed_count + PAUSE_EVERY;
        while (vertices_sent < directed_count + RANDOM_VERTICES) begin
            sender_calm   = ($urandom_range(0, 3) == 0);
            receiver_calm = ($urandom_range(0, 3) == 0);
            len       = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            prim_mode = t_mode'($urandom_range(0, 1));
            narrow    = ($urandom_range(0, 2) == 0);
            flaw      = $urandom_range(0, 9);
            for (int k = 0; k < len; k++) begin
                idx        = narrow ? 16'($urandom_range(0, 5)) : 16'($urandom);
                mode_bit   = (k == 0) ? prim_mode : t_mode'($urandom_range(0, 1));
                first_mark = (k == 0) && (flaw != 0);
                last_mark  = (k == len - 1) && (flaw != 1);
                if (flaw == 2 && k > 0) begin
                    first_mark = ($urandom_range(0, 5) == 0);
                    last_mark  = last_mark || ($urandom_range(0, 5) == 0);
                end
                send_vertex(idx, mode_bit, first_mark, last_mark);
            end
            if (vertices_sent >= next_pause) begin
                wait_drained();
                next_pause = vertices_sent + PAUSE_EVERY;
            end
        end

        // Let the last triangles come out, then watch for stray words a little longer.
        receiver_calm = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        failures = mismatches + triangles_pending;

        $display("Sent %0d vertices (%0d directed) in strip and fan primitives, broken framing mixed in.",
                 vertices_sent, directed_count);
        $display("Checked %0d triangles in %0d cycles, with random stalls on both sides.",
                 triangles_checked, cycle_count);
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d failures", failures);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/sfta_pkg.sv
hw/rtl/sfta_front.sv
hw/rtl/sfta_fifo.sv
hw/rtl/sfta_back.sv
hw/rtl/strip_fan_triangle_assembly.sv
hw/rtl/sfta_checker.sv
bench/triangle_stream_check.sv
bench/testbench.sv
